// ----- design/srfp_pkg.sv -----
// srfp_pkg: types and constants shared by the sensor response frame parser
// holds command and status codes, frame constants and the timeout reset value
// no dependencies
package srfp_pkg;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_START = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_BAD_CODE = 2'd3
	} status_t;

	localparam logic [7:0]  START_BYTE    = 8'hFF;
	localparam logic [7:0]  REPLY_READ    = 8'h86;
	localparam logic [8:0]  TEMP_OFFSET   = 9'd40;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
	localparam logic [3:0]  LAST_DATA     = 4'd7;
	localparam logic [3:0]  CHECK_POS     = 4'd8;

endpackage

// ----- design/srfp_if.sv -----
// srfp_if: valid/ready channel interfaces of the sensor response frame parser
// request channel, result channel and configuration write channel
// depends on srfp_pkg
interface srfp_in_if;
	logic               valid;
	logic               ready;
	srfp_pkg::cmd_t     command;
	logic [7:0]         rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface srfp_out_if;
	logic                valid;
	logic                ready;
	srfp_pkg::status_t   status;
	logic [15:0]         co2_ppm;
	logic signed [8:0]   temperature;

	modport source (output valid, output status, output co2_ppm, output temperature,
		input ready);
	modport sink (input valid, input status, input co2_ppm, input temperature,
		output ready);
endinterface

interface srfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/sensor_response_frame_parser.sv -----
// sensor_response_frame_parser: nine-byte gas sensor reply frame parser
// depends on srfp_pkg and the channel interfaces in srfp_if
//
// in_req carries one request per cycle: a received byte, a millisecond tick or a
// start command. a start arms a read; bytes before the 0xFF start byte are dropped,
// the next seven bytes are collected and the checksum byte produces one result on
// out_res. a timeout result is given once the ticks counted while armed exceed
// timeout_ticks. cfg writes timeout_ticks and is always ready; write it only idle.
// a request is registered in the input register, then evaluated into the result
// register, which drives out_res.valid and its fields.
// throughput: one request per cycle while the result register can advance, as the
// state update between the input register and the result register is combinational.
// when the receiver stalls the result register holds; one further request is
// taken into the input register, then in_req.ready drops until the result leaves.
// reset: disarmed, counters clear, timeout_ticks back to 1000, no result pending.
module sensor_response_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	srfp_in_if.sink    in_req,
	srfp_out_if.source out_res,
	srfp_cfg_if.sink   cfg
);
	import srfp_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	logic        armed_q;
	logic [3:0]  byte_count_q;
	logic [15:0] elapsed_q;
	logic [7:0]  sum_q;
	logic [7:0]  code_q;
	logic [23:0] reading_q;
	logic [15:0] timeout_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] ppm_q;
	logic signed [8:0] temp_q;

	logic [15:0] elapsed_nx;
	logic [7:0]  check_exp;
	logic        fire;

	assign adv          = !out_valid_q || out_res.ready;
	assign in_req.ready = !valid_s1 || adv;
	assign cfg.ready    = 1'b1;
	assign fire         = valid_s1 && adv;

	assign elapsed_nx = (elapsed_q == TICKS_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign check_exp  = 8'd0 - sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_req.ready) begin
			valid_s1 <= in_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.ready && in_req.valid) begin
			cmd_s1  <= in_req.command;
			byte_s1 <= in_req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			byte_count_q <= '0;
			elapsed_q    <= '0;
			sum_q        <= '0;
			code_q       <= '0;
			reading_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			ppm_q        <= '0;
			temp_q       <= '0;
		end else begin
			if (out_res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				case (cmd_s1)
					CMD_START: begin
						armed_q      <= 1'b1;
						byte_count_q <= '0;
						elapsed_q    <= '0;
						sum_q        <= '0;
						code_q       <= '0;
						reading_q    <= '0;
					end
					CMD_TICK: begin
						if (armed_q) begin
							elapsed_q <= elapsed_nx;
							if (elapsed_nx > timeout_q) begin
								armed_q     <= 1'b0;
								out_valid_q <= 1'b1;
								status_q    <= ST_TIMEOUT;
								ppm_q       <= '0;
								temp_q      <= '0;
							end
						end
					end
					CMD_BYTE: begin
						if (armed_q) begin
							if (byte_count_q == 4'd0) begin
								if (byte_s1 == START_BYTE) begin
									byte_count_q <= 4'd1;
								end
							end else if (byte_count_q <= LAST_DATA) begin
								sum_q        <= sum_q + byte_s1;
								byte_count_q <= byte_count_q + 4'd1;
								if (byte_count_q == 4'd1) begin
									code_q <= byte_s1;
								end else if (byte_count_q <= 4'd4) begin
									reading_q <= {reading_q[15:0], byte_s1};
								end
							end else begin
								armed_q      <= 1'b0;
								byte_count_q <= '0;
								out_valid_q  <= 1'b1;
								ppm_q        <= '0;
								temp_q       <= '0;
								if (code_q != REPLY_READ) begin
									status_q <= ST_BAD_CODE;
								end else if (check_exp != byte_s1) begin
									status_q <= ST_CHECKSUM;
								end else begin
									status_q <= ST_OK;
									ppm_q    <= reading_q[23:8];
									temp_q   <= $signed({1'b0, reading_q[7:0]} - TEMP_OFFSET);
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_res.valid       = out_valid_q;
	assign out_res.status      = status_q;
	assign out_res.co2_ppm     = ppm_q;
	assign out_res.temperature = temp_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CHECK_POS)
		else $error("byte count beyond checksum position");

	a_result_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(armed_q) && !armed_q)
		else $error("result without an armed read or without disarming");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> (ppm_q == 16'd0) && (temp_q == 9'sd0))
		else $error("failed result carries reading data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_req.ready |-> valid_s1 && out_valid_q && !out_res.ready)
		else $error("request channel stalled without a pending result");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for sensor_response_frame_parser, top module last in sim
// drives reply bytes, ticks and start requests, predicts every result and checks it per field
// depends on srfp_pkg, the channel interfaces in srfp_if and the parser rtl
module tb;
	import srfp_pkg::*;

	typedef struct {
		status_t           status;
		logic [15:0]       co2_ppm;
		logic signed [8:0] temperature;
	} reading_t;

	logic clk;
	logic arst_n;

	srfp_in_if  in_req ();
	srfp_out_if out_res ();
	srfp_cfg_if cfg ();

	sensor_response_frame_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_req  (in_req),
		.out_res (out_res),
		.cfg     (cfg)
	);

	// predicted parser state
	logic        m_armed;
	logic [3:0]  m_count;
	logic [15:0] m_ticks;
	logic [7:0]  m_sum;
	logic [7:0]  m_code;
	logic [23:0] m_data;
	logic [15:0] m_limit;

	reading_t expected_readings[$];

	int  requests_sent;
	int  mismatches;
	int  ok_seen;
	int  timeouts_seen;
	int  checksum_seen;
	int  bad_code_seen;
	bit  gaps_on;
	int  hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout: run did not complete");
		$display("FAILURE");
		$finish;
	end

	task automatic clear_read_state();
		m_count = '0;
		m_ticks = '0;
		m_sum   = '0;
		m_code  = '0;
		m_data  = '0;
	endtask

	task automatic predict_reading(input cmd_t c, input logic [7:0] b);
		reading_t   r;
		bit         give;
		logic [7:0] want_sum;
		give          = 1'b0;
		r.status      = ST_OK;
		r.co2_ppm     = '0;
		r.temperature = '0;
		if (c == CMD_START) begin
			m_armed = 1'b1;
			clear_read_state();
		end else if (m_armed) begin
			if (c == CMD_TICK) begin
				if (m_ticks != TICKS_MAX)
					m_ticks = m_ticks + 16'd1;
				if (m_ticks > m_limit) begin
					m_armed  = 1'b0;
					r.status = ST_TIMEOUT;
					give     = 1'b1;
				end
			end else if (c == CMD_BYTE) begin
				if (m_count == 4'd0) begin
					if (b == START_BYTE)
						m_count = 4'd1;
				end else if (m_count <= LAST_DATA) begin
					m_sum = m_sum + b;
					if (m_count == 4'd1)
						m_code = b;
					else if (m_count <= 4'd4)
						m_data = {m_data[15:0], b};
					m_count = m_count + 4'd1;
				end else begin
					m_armed  = 1'b0;
					m_count  = '0;
					want_sum = 8'h00 - m_sum;
					give     = 1'b1;
					if (m_code != REPLY_READ) begin
						r.status = ST_BAD_CODE;
					end else if (want_sum != b) begin
						r.status = ST_CHECKSUM;
					end else begin
						r.co2_ppm     = m_data[23:8];
						r.temperature = $signed({1'b0, m_data[7:0]} - TEMP_OFFSET);
					end
				end
			end
		end
		if (give)
			expected_readings.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && out_res.valid && out_res.ready) begin
			case (out_res.status)
				ST_OK:       ok_seen++;
				ST_TIMEOUT:  timeouts_seen++;
				ST_CHECKSUM: checksum_seen++;
				default:     bad_code_seen++;
			endcase
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected result, status", -1, out_res.status);
			end else begin
				want = expected_readings.pop_front();
				if (out_res.status !== want.status)
					report_mismatch("status", want.status, out_res.status);
				if (out_res.co2_ppm !== want.co2_ppm)
					report_mismatch("co2_ppm", want.co2_ppm, out_res.co2_ppm);
				if (out_res.temperature !== want.temperature)
					report_mismatch("temperature", want.temperature, out_res.temperature);
			end
		end
	end

	// result receiver, with a counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_res.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (gaps_on) begin
			out_res.ready <= ($urandom_range(99) >= 33);
		end else begin
			out_res.ready <= 1'b1;
		end
	end

	task automatic send_req(input cmd_t c, input logic [7:0] b);
		if (gaps_on && $urandom_range(99) < 33) begin
			in_req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_req.valid   <= 1'b1;
		in_req.command <= c;
		in_req.rx_byte <= b;
		@(posedge clk);
		while (!in_req.ready) @(posedge clk);
		predict_reading(c, b);
		requests_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input int tick_pct);
		if ($urandom_range(99) < tick_pct)
			send_req(CMD_TICK, 8'($urandom));
		send_req(CMD_BYTE, b);
	endtask

	task automatic send_frame(input logic [7:0] code, input logic [15:0] ppm,
		input logic [7:0] temp_byte, input bit good, input int tick_pct);
		logic [7:0] body [7];
		logic [7:0] sum;
		logic [7:0] chk;
		body = '{code, ppm[15:8], ppm[7:0], temp_byte, 8'($urandom), 8'($urandom),
			8'($urandom)};
		sum = '0;
		foreach (body[i])
			sum = sum + body[i];
		chk = 8'h00 - sum;
		if (!good)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_byte(START_BYTE, tick_pct);
		foreach (body[i])
			send_byte(body[i], tick_pct);
		send_byte(chk, tick_pct);
	endtask

	task automatic drain();
		in_req.valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		m_limit = v;
	endtask

	task automatic test_idle_ignored();
		send_req(CMD_BYTE, START_BYTE);
		send_req(CMD_TICK, 8'h00);
		send_req(CMD_NONE, 8'hFF);
		send_req(CMD_START, 8'h00);
		send_req(CMD_NONE, START_BYTE);
		send_req(CMD_BYTE, 8'h00);
		send_req(CMD_BYTE, 8'h7F);
	endtask

	task automatic test_frame_statuses();
		// ppm at its top, temperature at its bottom
		send_frame(REPLY_READ, 16'hFFFF, 8'h00, 1'b1, 0);
		send_req(CMD_BYTE, START_BYTE);
		send_req(CMD_START, 8'h00);
		send_frame(REPLY_READ, 16'h0000, 8'hFF, 1'b1, 0);
		// wrong reply code wins over a bad checksum
		send_req(CMD_START, 8'h00);
		send_frame(8'h12, 16'h1234, 8'h40, 1'b0, 0);
		send_req(CMD_START, 8'h00);
		send_frame(REPLY_READ, 16'h01F4, 8'h41, 1'b0, 0);
		// restart in mid frame
		send_req(CMD_START, 8'h00);
		send_req(CMD_BYTE, START_BYTE);
		send_req(CMD_BYTE, REPLY_READ);
		send_req(CMD_BYTE, 8'h01);
		send_req(CMD_START, 8'h00);
		send_frame(REPLY_READ, 16'h0190, 8'h3C, 1'b1, 0);
	endtask

	task automatic test_timeout();
		set_limit(16'd1);
		send_req(CMD_START, 8'h00);
		send_req(CMD_TICK, 8'h00);
		send_req(CMD_TICK, 8'h00);
		send_req(CMD_TICK, 8'h00);
		send_req(CMD_BYTE, START_BYTE);
		// timeout part way through a frame, the rest is dropped
		send_req(CMD_START, 8'h00);
		send_req(CMD_BYTE, START_BYTE);
		send_req(CMD_BYTE, REPLY_READ);
		send_req(CMD_BYTE, 8'h03);
		send_req(CMD_TICK, 8'h00);
		send_req(CMD_TICK, 8'h00);
		repeat (5) send_req(CMD_BYTE, 8'h20);
	endtask

	task automatic test_top_limit();
		gaps_on = 1'b0;
		set_limit(TICKS_MAX);
		send_req(CMD_START, 8'h00);
		repeat (100) send_req(CMD_TICK, 8'h00);
		send_frame(REPLY_READ, 16'd400, 8'd65, 1'b1, 0);
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		set_limit(16'd1);
		hold_left = 300;
		repeat (6) begin
			send_req(CMD_START, 8'h00);
			send_req(CMD_TICK, 8'h00);
			send_req(CMD_TICK, 8'h00);
		end
		send_req(CMD_START, 8'h00);
		send_frame(REPLY_READ, 16'h0800, 8'd60, 1'b1, 0);
	endtask

	task automatic random_phase(input int n);
		int start_count;
		int kind;
		start_count = requests_sent;
		while (requests_sent - start_count < n) begin
			kind = $urandom_range(99);
			if (kind < 65) begin
				send_req(CMD_START, 8'($urandom));
				repeat ($urandom_range(0, 2)) send_req(CMD_BYTE, 8'($urandom_range(0, 254)));
				send_frame(($urandom_range(9) != 0) ? REPLY_READ : 8'($urandom),
					16'($urandom), 8'($urandom), $urandom_range(99) < 85, 6);
			end else if (kind < 82) begin
				repeat ($urandom_range(1, 6)) send_req(cmd_t'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				send_req(CMD_START, 8'($urandom));
				send_req(CMD_BYTE, START_BYTE);
				repeat ($urandom_range(0, 6)) send_req(CMD_BYTE, 8'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_limit(TIMEOUT_RESET);
		random_phase(350);
		set_limit(16'($urandom_range(2, 40)));
		random_phase(350);
		set_limit(16'd1);
		random_phase(250);
		gaps_on = 1'b0;
		set_limit(16'($urandom_range(1, 65535)));
		random_phase(350);
		gaps_on = 1'b1;
		set_limit(TICKS_MAX);
		random_phase(250);
		set_limit(16'($urandom_range(5, 15)));
		random_phase(200);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_req.valid   = 1'b0;
		in_req.command = CMD_BYTE;
		in_req.rx_byte = 8'h00;
		cfg.valid      = 1'b0;
		cfg.data       = 16'h0000;
		out_res.ready  = 1'b0;
		gaps_on        = 1'b1;
		hold_left      = 0;
		requests_sent  = 0;
		mismatches     = 0;
		m_armed        = 1'b0;
		m_limit        = TIMEOUT_RESET;
		clear_read_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ignored();
		test_frame_statuses();
		test_timeout();
		test_top_limit();
		test_backpressure();
		test_random_traffic();

		drain();
		$display("sent %0d requests over timeout limits from 1 to 65535, with stalls",
			requests_sent);
		$display("results: %0d ok, %0d timeout, %0d checksum error, %0d wrong reply code",
			ok_seen, timeouts_seen, checksum_seen, bad_code_seen);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
